@@ src/critical_path_schedule_top_assert.svh @@
// Assertion macros for the critical path schedule block.
`ifndef CRITICAL_PATH_SCHEDULE_TOP_ASSERT_SVH
`define CRITICAL_PATH_SCHEDULE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define CPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CPS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CPS_ASSERT(lbl, prop, msg)
`define CPS_ASSERT_RST(lbl, prop, msg)
`endif

`endif

@@ src/cps_pkg.sv @@
// Shared constants and types for the critical path schedule block.
`timescale 1ns / 1ps
package cps_pkg;

  localparam int MAX_NODES      = 32;
  localparam int NODE_W         = $clog2(MAX_NODES);
  localparam int DUR_BITS       = 16;
  localparam int IN_DUR_W       = 16;
  localparam int SUCC_W         = 32;
  localparam int CFG_W          = 6;
  localparam int VAL_W          = 21;
  localparam int SLACK_W        = 22;
  localparam int ALU_W          = 23;
  localparam int NODE_COUNT_RST = 32;

  typedef struct packed {
    logic             sub;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic [ALU_W-1:0] c;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] sum;
    logic             gt;
  } alu_rsp_t;

endpackage

@@ src/cps_alu.sv @@
// Shared add/subtract and signed compare unit.
`timescale 1ns / 1ps
module cps_alu (
  input  cps_pkg::alu_req_t req,
  output cps_pkg::alu_rsp_t rsp
);

  logic [cps_pkg::ALU_W-1:0] sum;

  assign sum     = req.sub ? (req.a - req.b) : (req.a + req.b);
  assign rsp.sum = sum;
  assign rsp.gt  = $signed(sum) > $signed(req.c);

endmodule

@@ src/cps_graph_mem.sv @@
// Per-node successor masks and durations.
`timescale 1ns / 1ps
module cps_graph_mem (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [cps_pkg::NODE_W-1:0]     wr_addr,
  input  logic [cps_pkg::MAX_NODES-1:0]  wr_adj,
  input  logic [cps_pkg::DUR_BITS-1:0]   wr_dur,
  input  logic [cps_pkg::NODE_W-1:0]     adj_addr,
  output logic [cps_pkg::MAX_NODES-1:0]  adj_row,
  input  logic [cps_pkg::NODE_W-1:0]     dur_addr,
  output logic [cps_pkg::DUR_BITS-1:0]   dur_val
);

  logic [cps_pkg::MAX_NODES-1:0] adj_mem [cps_pkg::MAX_NODES];
  logic [cps_pkg::DUR_BITS-1:0]  dur_mem [cps_pkg::MAX_NODES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      adj_mem[wr_addr] <= wr_adj;
      dur_mem[wr_addr] <= wr_dur;
    end
  end

  assign adj_row = adj_mem[adj_addr];
  assign dur_val = dur_mem[dur_addr];

endmodule

@@ src/cps_seq.sv @@
// Sequencer: forward and backward relaxation passes, then per-node result emit.
`timescale 1ns / 1ps
module cps_seq (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [cps_pkg::CFG_W-1:0]         n_cfg,
  output logic                              busy,
  output logic [cps_pkg::NODE_W-1:0]        adj_addr,
  input  logic [cps_pkg::MAX_NODES-1:0]     adj_row,
  output logic [cps_pkg::NODE_W-1:0]        dur_addr,
  input  logic [cps_pkg::DUR_BITS-1:0]      dur_val,
  output cps_pkg::alu_req_t                 alu_req,
  input  cps_pkg::alu_rsp_t                 alu_rsp,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [cps_pkg::NODE_W-1:0]        out_node,
  output logic [cps_pkg::VAL_W-1:0]         out_earliest_start,
  output logic [cps_pkg::VAL_W-1:0]         out_tail_length,
  output logic [cps_pkg::VAL_W-1:0]         out_path_through,
  output logic signed [cps_pkg::SLACK_W-1:0] out_slack,
  output logic                              out_on_critical,
  output logic [cps_pkg::VAL_W-1:0]         out_project_length,
  output logic                              out_last
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FROW = 3'd1;
  localparam logic [2:0] S_FREL = 3'd2;
  localparam logic [2:0] S_BROW = 3'd3;
  localparam logic [2:0] S_BREL = 3'd4;
  localparam logic [2:0] S_OA   = 3'd5;
  localparam logic [2:0] S_OB   = 3'd6;
  localparam logic [2:0] S_OC   = 3'd7;

  localparam int VPAD = cps_pkg::ALU_W - cps_pkg::VAL_W;
  localparam int DPAD = cps_pkg::ALU_W - cps_pkg::DUR_BITS;

  logic [2:0]                    state_r, state_nxt;
  logic [cps_pkg::NODE_W-1:0]    i_r, i_nxt;
  logic [cps_pkg::NODE_W-1:0]    j_r, j_nxt;
  logic [cps_pkg::NODE_W-1:0]    last_r, last_nxt;
  logic [cps_pkg::VAL_W-1:0]     base_r, base_nxt;
  logic [cps_pkg::VAL_W-1:0]     acc_r, acc_nxt;
  logic [cps_pkg::VAL_W-1:0]     project_r, project_nxt;
  logic [cps_pkg::MAX_NODES-1:0] row_r, row_nxt;
  logic [cps_pkg::MAX_NODES-1:0] e_vld_r, e_vld_nxt;
  logic [cps_pkg::MAX_NODES-1:0] t_vld_r, t_vld_nxt;
  logic                          out_valid_r, out_valid_nxt;

  logic [cps_pkg::VAL_W-1:0] e_mem [cps_pkg::MAX_NODES];
  logic [cps_pkg::VAL_W-1:0] t_mem [cps_pkg::MAX_NODES];

  logic [cps_pkg::NODE_W-1:0] e_addr, t_addr;
  logic [cps_pkg::VAL_W-1:0]  e_rd, t_rd;
  logic                       e_we, t_we, out_load;
  logic [cps_pkg::NODE_W-1:0] last_clamp;

  logic [cps_pkg::NODE_W-1:0]         node_r;
  logic [cps_pkg::VAL_W-1:0]          es_r, tl_r, pt_r, pl_r;
  logic signed [cps_pkg::SLACK_W-1:0] slack_r;
  logic                               crit_r, last_flag_r;

  // node count 0 acts as 1, above the maximum acts as the maximum
  always_comb begin
    if (n_cfg == '0) begin
      last_clamp = '0;
    end else if (int'(n_cfg) > cps_pkg::MAX_NODES) begin
      last_clamp = cps_pkg::NODE_W'(cps_pkg::MAX_NODES - 1);
    end else begin
      last_clamp = cps_pkg::NODE_W'(n_cfg - 1'b1);
    end
  end

  assign e_addr   = (state_r == S_FREL) ? j_r : i_r;
  assign t_addr   = (state_r == S_BREL) ? j_r : i_r;
  assign adj_addr = (state_r == S_BREL) ? j_r : i_r;
  assign dur_addr = i_r;
  assign e_rd     = e_vld_r[e_addr] ? e_mem[e_addr] : '0;
  assign t_rd     = t_vld_r[t_addr] ? t_mem[t_addr] : '0;
  assign busy     = (state_r != S_IDLE);

  always_comb begin
    alu_req.sub = 1'b0;
    alu_req.a   = '0;
    alu_req.b   = '0;
    alu_req.c   = '0;
    case (state_r)
      S_FROW, S_OA: begin
        alu_req.a = {{VPAD{1'b0}}, e_rd};
        alu_req.b = {{DPAD{1'b0}}, dur_val};
      end
      S_FREL: begin
        alu_req.a = {{VPAD{1'b0}}, base_r};
        alu_req.c = {{VPAD{1'b0}}, e_rd};
      end
      S_BROW: begin
        alu_req.a = {{VPAD{1'b0}}, t_rd};
        alu_req.b = {{DPAD{1'b0}}, dur_val};
      end
      S_BREL: begin
        alu_req.a = {{VPAD{1'b0}}, base_r};
        alu_req.c = {{VPAD{1'b0}}, t_rd};
      end
      S_OB: begin
        alu_req.a = {{VPAD{1'b0}}, acc_r};
        alu_req.b = {{VPAD{1'b0}}, t_rd};
      end
      S_OC: begin
        alu_req.sub = 1'b1;
        alu_req.a   = {{VPAD{1'b0}}, project_r};
        alu_req.b   = {{VPAD{1'b0}}, acc_r};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    last_nxt      = last_r;
    base_nxt      = base_r;
    acc_nxt       = acc_r;
    project_nxt   = project_r;
    row_nxt       = row_r;
    e_vld_nxt     = e_vld_r;
    t_vld_nxt     = t_vld_r;
    e_we          = 1'b0;
    t_we          = 1'b0;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          last_nxt  = last_clamp;
          i_nxt     = '0;
          e_vld_nxt = '0;
          t_vld_nxt = '0;
          state_nxt = S_FROW;
        end
      end
      S_FROW: begin
        base_nxt = alu_rsp.sum[cps_pkg::VAL_W-1:0];
        row_nxt  = adj_row;
        if (i_r == last_r) begin
          // sink row: its finish is the project length
          project_nxt = alu_rsp.sum[cps_pkg::VAL_W-1:0];
          state_nxt   = S_BROW;
        end else begin
          j_nxt     = i_r + 1'b1;
          state_nxt = S_FREL;
        end
      end
      S_FREL: begin
        if (row_r[j_r] && alu_rsp.gt) begin
          e_we = 1'b1;
          e_vld_nxt[j_r] = 1'b1;
        end
        if (j_r == last_r) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_FROW;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      S_BROW: begin
        base_nxt = alu_rsp.sum[cps_pkg::VAL_W-1:0];
        if (i_r == '0) begin
          state_nxt = S_OA;
        end else begin
          j_nxt     = i_r - 1'b1;
          state_nxt = S_BREL;
        end
      end
      S_BREL: begin
        // adj_row is node j's mask here; test edge j -> i
        if (adj_row[i_r] && alu_rsp.gt) begin
          t_we = 1'b1;
          t_vld_nxt[j_r] = 1'b1;
        end
        if (j_r == '0) begin
          i_nxt     = i_r - 1'b1;
          state_nxt = S_BROW;
        end else begin
          j_nxt = j_r - 1'b1;
        end
      end
      S_OA: begin
        acc_nxt   = alu_rsp.sum[cps_pkg::VAL_W-1:0];
        state_nxt = S_OB;
      end
      S_OB: begin
        acc_nxt   = alu_rsp.sum[cps_pkg::VAL_W-1:0];
        state_nxt = S_OC;
      end
      S_OC: begin
        if (!out_valid_r || !out_stall) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          if (i_r == last_r) begin
            state_nxt = S_IDLE;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = S_OA;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      e_vld_r     <= '0;
      t_vld_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      e_vld_r     <= e_vld_nxt;
      t_vld_r     <= t_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    last_r    <= last_nxt;
    base_r    <= base_nxt;
    acc_r     <= acc_nxt;
    project_r <= project_nxt;
    row_r     <= row_nxt;
  end

  always_ff @(posedge clk) begin
    if (e_we) begin
      e_mem[j_r] <= base_r;
    end
    if (t_we) begin
      t_mem[j_r] <= base_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      node_r      <= i_r;
      es_r        <= e_rd;
      tl_r        <= t_rd;
      pt_r        <= acc_r;
      slack_r     <= alu_rsp.sum[cps_pkg::SLACK_W-1:0];
      crit_r      <= (alu_rsp.sum == '0);
      pl_r        <= project_r;
      last_flag_r <= (i_r == last_r);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_node           = node_r;
  assign out_earliest_start = es_r;
  assign out_tail_length    = tl_r;
  assign out_path_through   = pt_r;
  assign out_slack          = slack_r;
  assign out_on_critical    = crit_r;
  assign out_project_length = pl_r;
  assign out_last           = last_flag_r;

endmodule

@@ src/critical_path_schedule_top.sv @@
// Channel   | handshake            | payload
// in        | in_valid / in_stall  | in_kind, in_node_index, in_duration, in_successors
// out       | out_valid / out_stall| out_node .. out_last, one beat per node
// cfg       | cfg_wr_en            | cfg_node_count
//
// A load beat is taken whenever the block is idle. A compute beat runs a forward and a
// backward relaxation pass over n nodes: the single add/compare unit does one edge
// relaxation per cycle in each pass, then three steps per emitted node. in_stall is high
// for the whole compute. A stalled out beat holds the last emit step. Reset is
// synchronous; no clearing pass, per-compute state is cleared by valid bits.
`timescale 1ns / 1ps
`include "critical_path_schedule_top_assert.svh"
module critical_path_schedule_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [cps_pkg::CFG_W-1:0]          cfg_node_count,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_kind,
  input  logic [cps_pkg::NODE_W-1:0]         in_node_index,
  input  logic [cps_pkg::IN_DUR_W-1:0]       in_duration,
  input  logic [cps_pkg::SUCC_W-1:0]         in_successors,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [cps_pkg::NODE_W-1:0]         out_node,
  output logic [cps_pkg::VAL_W-1:0]          out_earliest_start,
  output logic [cps_pkg::VAL_W-1:0]          out_tail_length,
  output logic [cps_pkg::VAL_W-1:0]          out_path_through,
  output logic signed [cps_pkg::SLACK_W-1:0] out_slack,
  output logic                               out_on_critical,
  output logic [cps_pkg::VAL_W-1:0]          out_project_length,
  output logic                               out_last
);

  logic [cps_pkg::CFG_W-1:0]     node_count_r;
  logic                          busy, in_take;
  logic [cps_pkg::NODE_W-1:0]    adj_addr, dur_addr;
  logic [cps_pkg::MAX_NODES-1:0] adj_row;
  logic [cps_pkg::DUR_BITS-1:0]  dur_val;
  cps_pkg::alu_req_t             alu_req;
  cps_pkg::alu_rsp_t             alu_rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= cps_pkg::CFG_W'(cps_pkg::NODE_COUNT_RST);
    end else if (cfg_wr_en) begin
      node_count_r <= cfg_node_count;
    end
  end

  assign in_stall = busy;
  assign in_take  = in_valid && !busy;

  cps_graph_mem u_mem (
    .clk      (clk),
    .wr_en    (in_take && !in_kind),
    .wr_addr  (in_node_index),
    .wr_adj   (cps_pkg::MAX_NODES'(in_successors)),
    .wr_dur   (cps_pkg::DUR_BITS'(in_duration)),
    .adj_addr (adj_addr),
    .adj_row  (adj_row),
    .dur_addr (dur_addr),
    .dur_val  (dur_val)
  );

  cps_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  cps_seq u_seq (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (in_take && in_kind),
    .n_cfg              (node_count_r),
    .busy               (busy),
    .adj_addr           (adj_addr),
    .adj_row            (adj_row),
    .dur_addr           (dur_addr),
    .dur_val            (dur_val),
    .alu_req            (alu_req),
    .alu_rsp            (alu_rsp),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_node           (out_node),
    .out_earliest_start (out_earliest_start),
    .out_tail_length    (out_tail_length),
    .out_path_through   (out_path_through),
    .out_slack          (out_slack),
    .out_on_critical    (out_on_critical),
    .out_project_length (out_project_length),
    .out_last           (out_last)
  );

  `CPS_ASSERT(a_start_busy, (in_valid && !in_stall && in_kind) |=> in_stall, "compute beat did not make block busy")
  `CPS_ASSERT(a_crit_slack, out_valid |-> (out_on_critical == (out_slack == 0)), "critical flag disagrees with slack")
  `CPS_ASSERT_RST(a_rst_idle, !rst_n |=> (!out_valid && !in_stall), "block not idle after reset")

endmodule

@@ tb/tb.sv @@
// Self-checking bench for critical_path_schedule_top: scoreboard-predicted node rows.
`timescale 1ns / 1ps
module tb;
  import cps_pkg::*;

  localparam int  SETTLE_CYCLES = 8;
  localparam int  DRAIN_CYCLES  = 32;
  localparam int  HOLD_CYCLES   = 1500;
  localparam int  BEAT_TARGET   = 280;
  localparam real RUN_LIMIT_NS  = 20000000.0;

  typedef enum logic {BEAT_LOAD = 1'b0, BEAT_COMPUTE = 1'b1} beat_kind_t;

  typedef struct packed {
    logic [NODE_W-1:0]         node;
    logic [VAL_W-1:0]          est;
    logic [VAL_W-1:0]          tail;
    logic [VAL_W-1:0]          path;
    logic signed [SLACK_W-1:0] slack;
    logic                      crit;
    logic [VAL_W-1:0]          proj;
    logic                      last;
  } node_row_t;

  class cpm_tracker_t;
    logic [SUCC_W-1:0]   succ_mem [MAX_NODES];
    logic [DUR_BITS-1:0] dur_mem  [MAX_NODES];
    logic [CFG_W-1:0]    node_count;
    node_row_t           rows_due [$];
    int                  mismatches;

    function new();
      node_count = CFG_W'(NODE_COUNT_RST);
      mismatches = 0;
      foreach (succ_mem[i]) begin
        succ_mem[i] = '0;
        dur_mem[i]  = '0;
      end
    endfunction

    function int active_nodes();
      if (node_count == 0) return 1;
      if (node_count > MAX_NODES) return MAX_NODES;
      return int'(node_count);
    endfunction

    task flag_mismatch(string what);
      mismatches++;
      $display("%0t ns mismatch: %s", $time, what);
    endtask

    // longest-path passes forward and backward, then one row per node
    function void forecast_schedule();
      int          n;
      int unsigned est [MAX_NODES];
      int unsigned tl  [MAX_NODES];
      int unsigned proj;
      int unsigned path;
      node_row_t   row;
      n = active_nodes();
      foreach (est[i]) begin
        est[i] = 0;
        tl[i]  = 0;
      end
      for (int i = 0; i < n; i++)
        for (int j = i + 1; j < n; j++)
          if (succ_mem[i][j] && est[j] < est[i] + dur_mem[i]) est[j] = est[i] + dur_mem[i];
      for (int i = n - 1; i >= 0; i--)
        for (int j = i - 1; j >= 0; j--)
          if (succ_mem[j][i] && tl[j] < tl[i] + dur_mem[i]) tl[j] = tl[i] + dur_mem[i];
      proj = est[n-1] + dur_mem[n-1];
      for (int i = 0; i < n; i++) begin
        path      = est[i] + dur_mem[i] + tl[i];
        row.node  = NODE_W'(i);
        row.est   = VAL_W'(est[i]);
        row.tail  = VAL_W'(tl[i]);
        row.path  = VAL_W'(path);
        row.slack = SLACK_W'(proj - path);
        row.crit  = (path == proj);
        row.proj  = VAL_W'(proj);
        row.last  = (i == n - 1);
        rows_due  = {rows_due, row};
      end
    endfunction

    function void note_beat(beat_kind_t kind, logic [NODE_W-1:0] idx,
                            logic [IN_DUR_W-1:0] dur, logic [SUCC_W-1:0] succ);
      if (kind == BEAT_LOAD) begin
        succ_mem[idx] = succ;
        dur_mem[idx]  = DUR_BITS'(dur);
      end else begin
        forecast_schedule();
      end
    endfunction

    task compare_field(string name, int node, longint got, longint want);
      if (got != want)
        flag_mismatch($sformatf("node %0d %s: got %0d, want %0d", node, name, got, want));
    endtask

    task check_row(node_row_t got);
      node_row_t want;
      if (rows_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected beat for node %0d", got.node));
        return;
      end
      want = rows_due.pop_front();
      compare_field("out_node", int'(want.node), longint'(got.node), longint'(want.node));
      compare_field("earliest_start", int'(want.node), longint'(got.est),
                    longint'(want.est));
      compare_field("tail_length", int'(want.node), longint'(got.tail),
                    longint'(want.tail));
      compare_field("path_through", int'(want.node), longint'(got.path),
                    longint'(want.path));
      compare_field("slack", int'(want.node), longint'(got.slack), longint'(want.slack));
      compare_field("on_critical", int'(want.node), longint'(got.crit),
                    longint'(want.crit));
      compare_field("project_length", int'(want.node), longint'(got.proj),
                    longint'(want.proj));
      compare_field("last", int'(want.node), longint'(got.last), longint'(want.last));
    endtask
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_wr_en;
  logic [CFG_W-1:0]           cfg_node_count;
  logic                       in_valid;
  logic                       in_stall;
  logic                       in_kind;
  logic [NODE_W-1:0]          in_node_index;
  logic [IN_DUR_W-1:0]        in_duration;
  logic [SUCC_W-1:0]          in_successors;
  logic                       out_valid;
  logic                       out_stall;
  logic [NODE_W-1:0]          out_node;
  logic [VAL_W-1:0]           out_earliest_start;
  logic [VAL_W-1:0]           out_tail_length;
  logic [VAL_W-1:0]           out_path_through;
  logic signed [SLACK_W-1:0]  out_slack;
  logic                       out_on_critical;
  logic [VAL_W-1:0]           out_project_length;
  logic                       out_last;

  cpm_tracker_t         cpm;
  int                   beats_sent;
  int                   send_idle_pct;
  int                   recv_idle_pct;
  bit                   hold_req;
  logic [MAX_NODES-1:0] loaded;

  critical_path_schedule_top uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_node_count     (cfg_node_count),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_node_index      (in_node_index),
    .in_duration        (in_duration),
    .in_successors      (in_successors),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_node           (out_node),
    .out_earliest_start (out_earliest_start),
    .out_tail_length    (out_tail_length),
    .out_path_through   (out_path_through),
    .out_slack          (out_slack),
    .out_on_critical    (out_on_critical),
    .out_project_length (out_project_length),
    .out_last           (out_last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [IN_DUR_W-1:0] pick_duration();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return IN_DUR_W'($urandom_range(0, 15));
      3:       return IN_DUR_W'($urandom_range(60000, 65535));
      default: return IN_DUR_W'($urandom);
    endcase
  endfunction

  function automatic logic [SUCC_W-1:0] pick_successors(logic [NODE_W-1:0] idx);
    logic [SUCC_W-1:0] ahead;
    ahead = ~((SUCC_W'(2) << idx) - 1'b1);
    case ($urandom_range(0, 6))
      0:       return $urandom;
      1:       return $urandom & $urandom & $urandom;
      2:       return ahead & $urandom & $urandom;
      3:       return ahead & $urandom;
      4:       return SUCC_W'(2) << idx;
      5:       return '0;
      default: return '1;
    endcase
  endfunction

  task automatic send_beat(beat_kind_t kind, logic [NODE_W-1:0] idx,
                           logic [IN_DUR_W-1:0] dur, logic [SUCC_W-1:0] succ);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_node_index <= idx;
    in_duration   <= dur;
    in_successors <= succ;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    cpm.note_beat(kind, idx, dur, succ);
    if (kind == BEAT_LOAD) loaded[idx] = 1'b1;
    beats_sent++;
    if (beats_sent == 100) begin
      send_idle_pct = 46;
      recv_idle_pct = 34;
    end else if (beats_sent == 200) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  task automatic send_load(logic [NODE_W-1:0] idx);
    send_beat(BEAT_LOAD, idx, pick_duration(), pick_successors(idx));
  endtask

  // compute beats carry junk in the load fields
  task automatic send_compute();
    send_beat(BEAT_COMPUTE, NODE_W'($urandom), IN_DUR_W'($urandom), $urandom);
  endtask

  // register writes only with nothing in flight
  task automatic set_node_count(logic [CFG_W-1:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (cpm.rows_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_wr_en      <= 1'b1;
    cfg_node_count <= value;
    @(posedge clk);
    cpm.node_count = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // a few loads, fill any node in use that was never written, then usually a compute
  task automatic run_sequence(bit squeeze);
    int               n;
    int               k;
    int               roll;
    logic [NODE_W-1:0] idx;
    n = cpm.active_nodes();
    k = $urandom_range(1, 6);
    for (int i = 0; i < k; i++) begin
      if ($urandom_range(0, 4) == 0) idx = NODE_W'($urandom_range(0, MAX_NODES - 1));
      else idx = NODE_W'($urandom_range(0, n - 1));
      send_load(idx);
    end
    for (int i = 0; i < n; i++)
      if (!loaded[i]) send_load(NODE_W'(i));
    roll = $urandom_range(0, 19);
    if (squeeze) begin
      hold_req = 1'b1;
      send_compute();
      // these loads back up behind the held result stream
      repeat (4) send_load(NODE_W'($urandom_range(0, n - 1)));
    end else if (roll < 17) begin
      send_compute();
      if (roll == 0) send_compute();
    end
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin : watch_out
    node_row_t seen;
    if (rst_n && out_valid && !out_stall) begin
      seen.node  = out_node;
      seen.est   = out_earliest_start;
      seen.tail  = out_tail_length;
      seen.path  = out_path_through;
      seen.slack = out_slack;
      seen.crit  = out_on_critical;
      seen.proj  = out_project_length;
      seen.last  = out_last;
      cpm.check_row(seen);
    end
  end

  initial begin
    int               phase;
    int               roll;
    logic [CFG_W-1:0] cnt;
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_node_count = '0;
    in_valid       = 1'b0;
    in_kind        = BEAT_LOAD;
    in_node_index  = '0;
    in_duration    = '0;
    in_successors  = '0;
    beats_sent     = 0;
    send_idle_pct  = 34;
    recv_idle_pct  = 46;
    hold_req       = 1'b0;
    loaded         = '0;
    cpm            = new();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // single node, widest duration, every edge pointing nowhere useful
    set_node_count(CFG_W'(1));
    send_beat(BEAT_LOAD, NODE_W'(0), '1, '1);
    send_beat(BEAT_COMPUTE, '1, '1, '1);
    // count of zero behaves as one
    set_node_count(CFG_W'(0));
    send_beat(BEAT_LOAD, NODE_W'(0), '0, '0);
    send_beat(BEAT_COMPUTE, '0, '0, '0);
    // backward edge, edge past the sink, dead-end node with negative slack
    set_node_count(CFG_W'(4));
    send_beat(BEAT_LOAD, NODE_W'(1), IN_DUR_W'(7), 32'h0000_0009);
    send_beat(BEAT_LOAD, NODE_W'(0), IN_DUR_W'(3), 32'h0010_0006);
    send_beat(BEAT_LOAD, NODE_W'(2), '1, '0);
    send_beat(BEAT_LOAD, NODE_W'(3), IN_DUR_W'(1), '0);
    send_beat(BEAT_LOAD, NODE_W'(31), '0, '0);
    send_compute();

    phase = 0;
    while (beats_sent < BEAT_TARGET) begin
      case (phase)
        0:       cnt = CFG_W'(32);
        1:       cnt = CFG_W'(63);
        2:       cnt = CFG_W'(8);
        3:       cnt = CFG_W'(2);
        default: begin
          roll = $urandom_range(0, 19);
          if (roll < 12)      cnt = CFG_W'($urandom_range(1, 10));
          else if (roll < 17) cnt = CFG_W'($urandom_range(11, 32));
          else if (roll < 19) cnt = CFG_W'($urandom_range(33, 63));
          else                cnt = '0;
        end
      endcase
      set_node_count(cnt);
      for (int seq = $urandom_range(1, 3); seq > 0; seq--)
        run_sequence(phase == 2 && seq == 1);
      phase++;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (cpm.rows_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (cpm.mismatches == 0) $display("** critical_path_schedule_top: PASSED **");
    else $display("** critical_path_schedule_top: FAILED **");
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("** critical_path_schedule_top: FAILED **");
    $finish;
  end

endmodule

@@ critical_path_schedule_top.f @@
+incdir+src
src/cps_pkg.sv
src/cps_alu.sv
src/cps_graph_mem.sv
src/cps_seq.sv
src/critical_path_schedule_top.sv
tb/tb.sv
